@@ rtl/core/hcat_pkg.sv @@
// Shared types and codes for the host core allocator table.
package hcat_pkg;

  typedef enum logic [2:0] {
    OP_REGISTER     = 3'd0,
    OP_RELEASE_HOST = 3'd1,
    OP_QUERY        = 3'd2,
    OP_REQUEST_CORE = 3'd3,
    OP_RELEASE_CORE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_NO_CORE   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_INS,
    S_INSERT,
    S_SHIFT_DEL,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    WALK_NONE,
    WALK_SCAN,
    WALK_INS,
    WALK_DEL
  } walk_mode_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_HIT,
    WR_SHIFT,
    WR_NEW
  } wr_sel_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_ECHO,
    RES_QUERY,
    RES_GRANT
  } res_kind_t;

  typedef struct packed {
    logic [31:0] busy;
    logic [5:0]  cores;
    logic [7:0]  power;
    logic [7:0]  host;
  } entry_t;

  typedef struct packed {
    logic [31:0] usage;
    logic [7:0]  power;
    logic [5:0]  count;
    logic [4:0]  core;
    logic [7:0]  host;
    status_t     status;
  } result_t;

  typedef struct packed {
    logic       load_item;
    walk_mode_t walk_mode;
    logic       walk_en;
    logic       scan;
    wr_sel_t    wr_sel;
    logic       res_load;
    res_kind_t  res_kind;
    status_t    res_status;
    logic       used_inc;
    logic       used_dec;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic hit;
    logic rd_vld;
    logic walk_end;
    logic full;
    logic empty;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/core/hcat_dpath.sv @@
// Datapath: host table memory, walker, match logic, result and output registers.
module hcat_dpath import hcat_pkg::*; #(
  parameter int TABLE_ENTRIES = 16,
  parameter int MAX_CORES     = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  logic [2:0] in_op,
  input  logic [7:0] in_host,
  input  logic [5:0] in_cores,
  input  logic [7:0] in_power,
  input  logic [4:0] in_core_num,
  input  logic       out_ready,
  output logic       out_valid,
  output result_t    out_res
);

  localparam int IW = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [5:0] MaxC = 6'(MAX_CORES);

  // latched item
  op_t        op;
  logic [7:0] host;
  logic [7:0] power;
  logic [5:0] cores;
  logic [4:0] core_num;

  entry_t          mem [TABLE_ENTRIES];
  entry_t          rd_q;
  logic            rd_vld;
  logic [IW-1:0]   rd_idx;
  logic [IW-1:0]   src;
  logic            walk_up;
  logic [CW-1:0]   remain;
  logic [CW-1:0]   used;
  logic [CW-1:0]   pos;
  logic            pos_found;
  logic            issue;

  logic [31:0] lim_mask;
  logic [31:0] avail;
  logic [31:0] first;
  logic [4:0]  core_idx;
  logic        match;

  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  entry_t          wr_data;

  result_t res;
  result_t res_next;

  assign issue = cmd.walk_en && (remain != '0);

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op       <= op_t'(in_op);
      host     <= in_host;
      power    <= in_power;
      cores    <= (in_cores > MaxC) ? MaxC : in_cores;
      core_num <= in_core_num;
    end
  end

  // walker control
  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= issue && (cmd.walk_mode == WALK_NONE);
      unique case (cmd.walk_mode)
        WALK_SCAN: remain <= used;
        WALK_INS:  remain <= used - pos;
        WALK_DEL:  remain <= used - CW'(rd_idx) - CW'(1);
        default: begin
          if (issue) remain <= remain - CW'(1);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.walk_mode)
      WALK_SCAN: begin
        src     <= '0;
        walk_up <= 1'b1;
      end
      WALK_INS: begin
        src     <= IW'(used - CW'(1));
        walk_up <= 1'b0;
      end
      WALK_DEL: begin
        src     <= rd_idx + IW'(1);
        walk_up <= 1'b1;
      end
      default: begin
        if (issue) src <= walk_up ? src + IW'(1) : src - IW'(1);
      end
    endcase
  end

  // insertion point: first entry with a larger power index
  always_ff @(posedge clk) begin
    if (cmd.walk_mode == WALK_SCAN) begin
      pos       <= used;
      pos_found <= 1'b0;
    end else if (cmd.scan && rd_vld && !pos_found && (rd_q.power > power)) begin
      pos       <= CW'(rd_idx);
      pos_found <= 1'b1;
    end
  end

  // table memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q   <= mem[src];
    rd_idx <= src;
  end

  // lowest free core below the entry's core count
  always_comb begin
    lim_mask = '0;
    core_idx = '0;
    for (int i = 0; i < 32; i++) lim_mask[i] = (6'(i) < rd_q.cores);
    avail = ~rd_q.busy & lim_mask;
    first = avail & (~avail + 32'd1);
    for (int i = 0; i < 32; i++) begin
      if (first[i]) core_idx = core_idx | 5'(i);
    end
  end

  always_comb begin
    case (op)
      OP_REGISTER:     match = (rd_q.power == power) && (rd_q.host == host);
      OP_REQUEST_CORE: match = |avail;
      OP_RELEASE_HOST,
      OP_QUERY,
      OP_RELEASE_CORE: match = (rd_q.host == host);
      default:         match = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_idx;
    wr_data = rd_q;
    unique case (cmd.wr_sel)
      WR_HIT: begin
        wr_en = 1'b1;
        case (op)
          OP_REGISTER:     wr_data.cores = cores;
          OP_REQUEST_CORE: wr_data.busy  = rd_q.busy | first;
          OP_RELEASE_CORE: wr_data.busy  = rd_q.busy & ~(32'd1 << core_num);
          default:         wr_data = rd_q;
        endcase
      end
      WR_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = walk_up ? rd_idx - IW'(1) : rd_idx + IW'(1);
      end
      WR_NEW: begin
        wr_en         = 1'b1;
        wr_addr       = pos[IW-1:0];
        wr_data.host  = host;
        wr_data.power = power;
        wr_data.cores = cores;
        wr_data.busy  = '0;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.used_inc) begin
      used <= used + CW'(1);
    end else if (cmd.used_dec) begin
      used <= used - CW'(1);
    end
  end

  always_comb begin
    res_next        = '0;
    res_next.status = cmd.res_status;
    unique case (cmd.res_kind)
      RES_ECHO: res_next.host = host;
      RES_QUERY: begin
        res_next.host  = host;
        res_next.count = rd_q.cores;
        res_next.power = rd_q.power;
        res_next.usage = rd_q.busy;
      end
      RES_GRANT: begin
        res_next.host = rd_q.host;
        res_next.core = core_idx;
      end
      default: res_next.host = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) res <= res_next;
    if (cmd.out_load) out_res <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // hit is only looked at by the controller while it scans
  assign sts.op       = op;
  assign sts.hit      = rd_vld && match;
  assign sts.rd_vld   = rd_vld;
  assign sts.walk_end = (remain == '0) && !rd_vld;
  assign sts.full     = (used == CW'(TABLE_ENTRIES));
  assign sts.empty    = (used == '0);
  assign sts.out_free = !out_valid || out_ready;

endmodule

@@ rtl/core/hcat_ctrl.sv @@
// Controller state machine sequencing scan, shift, insert and result handoff.
module hcat_ctrl import hcat_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   op_ok;

  assign op_ok = (sts.op <= OP_RELEASE_CORE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (!op_ok) begin
          state_next = S_DONE;
        end else if (sts.hit) begin
          state_next = (sts.op == OP_RELEASE_HOST) ? S_SHIFT_DEL : S_DONE;
        end else if (sts.walk_end) begin
          state_next = ((sts.op == OP_REGISTER) && !sts.full) ? S_SHIFT_INS : S_DONE;
        end
      end
      S_SHIFT_INS: begin
        if (sts.walk_end) state_next = S_INSERT;
      end
      S_INSERT: state_next = S_DONE;
      S_SHIFT_DEL: begin
        if (sts.walk_end) state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          cmd.walk_mode = WALK_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (!op_ok) begin
          cmd.res_load   = 1'b1;
          cmd.res_kind   = RES_NONE;
          cmd.res_status = ST_OK;
        end else if (sts.hit) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_OK;
          case (sts.op) inside
            OP_QUERY: cmd.res_kind = RES_QUERY;
            OP_REQUEST_CORE: begin
              cmd.res_kind = RES_GRANT;
              cmd.wr_sel   = WR_HIT;
            end
            OP_RELEASE_HOST: begin
              cmd.res_kind  = RES_ECHO;
              cmd.walk_mode = WALK_DEL;
            end
            OP_REGISTER, OP_RELEASE_CORE: begin
              cmd.res_kind = RES_ECHO;
              cmd.wr_sel   = WR_HIT;
            end
            default: cmd.res_kind = RES_NONE;
          endcase
        end else if (sts.walk_end) begin
          cmd.res_load = 1'b1;
          case (sts.op) inside
            OP_REGISTER: begin
              cmd.res_kind = RES_ECHO;
              if (sts.full) begin
                cmd.res_status = ST_FULL;
              end else begin
                cmd.res_status = ST_OK;
                cmd.walk_mode  = WALK_INS;
              end
            end
            OP_REQUEST_CORE: begin
              cmd.res_kind   = RES_NONE;
              cmd.res_status = ST_NO_CORE;
            end
            default: begin
              cmd.res_kind   = RES_ECHO;
              cmd.res_status = ST_NOT_FOUND;
            end
          endcase
        end else begin
          cmd.walk_en = 1'b1;
        end
      end
      S_SHIFT_INS: begin
        cmd.walk_en = 1'b1;
        if (sts.rd_vld) cmd.wr_sel = WR_SHIFT;
      end
      S_INSERT: begin
        cmd.wr_sel   = WR_NEW;
        cmd.used_inc = 1'b1;
      end
      S_SHIFT_DEL: begin
        cmd.walk_en = 1'b1;
        if (sts.rd_vld) cmd.wr_sel = WR_SHIFT;
        if (sts.walk_end) cmd.used_dec = 1'b1;
      end
      S_DONE: begin
        if (sts.out_free) cmd.out_load = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

@@ rtl/core/host_core_allocator_table.sv @@
// Top level of the host core allocator table: stream ports, controller and datapath.
//
// Usage: one request item in on the s_axis channel, exactly one result item out on
// m_axis. s_axis_tuser carries the opcode (register, release host, query, request
// core, release core); s_axis_tdata carries the host id, core count, power index
// and core number. The table keeps hosts ordered by power index, ties in arrival
// order, in a single-port-write / registered-read memory of TABLE_ENTRIES rows.
// Timing: one item is worked at a time. The walker reads one row per cycle. An
// insert then shifts the rows above the insertion point, one row per cycle, and
// then writes the new row; a release host shifts the rows after the removed one
// the same way. A new item can be taken in the cycle after the result has moved
// to the output register.
// The output register decouples the sides: while m_axis is stalled the result
// waits there and the next item is already accepted and worked; only its own
// handoff waits for the output register to free up.
// Reset: synchronous, active high; the table is emptied at once (occupancy count
// cleared), the output register is emptied and s_axis_tready returns high.
module host_core_allocator_table import hcat_pkg::*; #(
  parameter int TABLE_ENTRIES = 16,
  parameter int MAX_CORES     = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] host_id, [13:8] core_count, [21:14] power_index, [26:22] core_number
  input  logic [31:0] s_axis_tdata,
  // [2:0] opcode
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [9:2] out_host, [14:10] out_core, [20:15] out_core_count,
  // [28:21] out_power_index, [60:29] out_core_usage, [63:61] zero
  output logic [63:0] m_axis_tdata
);

  cmd_t    cmd;
  sts_t    sts;
  result_t out_res;

  hcat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hcat_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_CORES     (MAX_CORES)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_op       (s_axis_tuser),
    .in_host     (s_axis_tdata[7:0]),
    .in_cores    (s_axis_tdata[13:8]),
    .in_power    (s_axis_tdata[21:14]),
    .in_core_num (s_axis_tdata[26:22]),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_res     (out_res)
  );

  // result item packing, status in the low bits
  assign m_axis_tdata = {3'b000, out_res.usage, out_res.power, out_res.count,
                         out_res.core, out_res.host, out_res.status};

  // a new row is only added when the table has room
  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    cmd.used_inc |-> !sts.full)
    else $error("insert into a full table");

  // a row is only removed from a non-empty table
  a_remove_row: assert property (@(posedge clk) disable iff (rst)
    cmd.used_dec |-> !sts.empty)
    else $error("remove from an empty table");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("item accepted while previous item in work");

  // never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register overwritten");

endmodule
